FILE: hw/rtl/i2c_rw_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master - shared definitions
// Opcodes, sequencer phase codes, header byte stages and word types.
// ----------------------------------------------------------------------------
package i2c_rw_pkg;

  // Opcodes of an input word
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_DATA  = 2'd3;

  // Bus sequencer phases
  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_ST0  = 5'd1;
  localparam logic [4:0] PH_ST1  = 5'd2;
  localparam logic [4:0] PH_ST2  = 5'd3;
  localparam logic [4:0] PH_WB0  = 5'd4;
  localparam logic [4:0] PH_WB1  = 5'd5;
  localparam logic [4:0] PH_WB2  = 5'd6;
  localparam logic [4:0] PH_WA0  = 5'd7;
  localparam logic [4:0] PH_WA1  = 5'd8;
  localparam logic [4:0] PH_WA2  = 5'd9;
  localparam logic [4:0] PH_RB0  = 5'd10;
  localparam logic [4:0] PH_RB1  = 5'd11;
  localparam logic [4:0] PH_RA0  = 5'd12;
  localparam logic [4:0] PH_RA1  = 5'd13;
  localparam logic [4:0] PH_RA2  = 5'd14;
  localparam logic [4:0] PH_SP0  = 5'd15;
  localparam logic [4:0] PH_SP1  = 5'd16;
  localparam logic [4:0] PH_WAIT = 5'd17;

  // Which header byte is on the wire
  localparam logic [1:0] STG_ADDR_W = 2'd0;
  localparam logic [1:0] STG_REG    = 2'd1;
  localparam logic [1:0] STG_ADDR_R = 2'd2;
  localparam logic [1:0] STG_DATA   = 2'd3;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned CountPortW  = 16;

  typedef struct packed {
    logic [1:0]            op;
    logic [6:0]            target_address;
    logic [7:0]            register_index;
    logic [CountPortW-1:0] byte_count;
    logic [7:0]            write_data;
    logic                  sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       byte_request;
    logic [7:0] read_data;
    logic       read_strobe;
    logic       finished;
    logic       nack_error;
    logic       busy_res;
  } result_t;

endpackage

FILE: hw/rtl/i2c_register_access_master_core.sv
// ----------------------------------------------------------------------------
// I2C register access master - top level
// Input word register, bus sequencer and result word register.
// ----------------------------------------------------------------------------
// Software-timed I2C master for register reads and writes. Each input word is
// one bus delay period (op tick) or a command: begin write, begin read, or
// supply the next write byte when byte_request_o asks for it. Every accepted
// word yields exactly one result word with the SCL/SDA levels to drive next,
// read data strobes, and the finished/nack_error status. A word passes through
// an input register and then a result register; out_valid_o rises once the
// held word steps into the result register, and one word is taken every cycle
// while out_stall_i is low; the sequencer state update between the two
// registers sets that rate. The result register only holds while out_stall_i
// is high, and the input side stalls once the input register is full behind
// it. COUNT_WIDTH (1..16) sets how many low bits of byte_count_i are used.
module i2c_register_access_master_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [6:0]  target_address_i,
  input  logic [7:0]  register_index_i,
  input  logic [15:0] byte_count_i,
  input  logic [7:0]  write_data_i,
  input  logic        sda_sample_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_level_o,
  output logic        sda_level_o,
  output logic        byte_request_o,
  output logic [7:0]  read_data_o,
  output logic        read_strobe_o,
  output logic        finished_o,
  output logic        nack_error_o,
  output logic        busy_res_o
);

  logic                in_valid_q, in_valid_d;
  i2c_rw_pkg::item_t   item_q;
  logic                out_valid_q, out_valid_d;
  i2c_rw_pkg::result_t result_q, result_d;
  logic                step;

  // Advance the sequencer whenever a held word can move into the result slot
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;

  assign in_valid_d  = in_stall_o ? in_valid_q : in_valid_i;
  assign out_valid_d = step ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the word on acceptance; hold it while stalled
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.op             <= op_i;
      item_q.target_address <= target_address_i;
      item_q.register_index <= register_index_i;
      item_q.byte_count     <= byte_count_i;
      item_q.write_data     <= write_data_i;
      item_q.sda_sample     <= sda_sample_i;
    end
  end

  i2c_rw_seq #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .result_o(result_d)
  );

  // Load a fresh result word on every step
  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_level_o    = result_q.scl_level;
  assign sda_level_o    = result_q.sda_level;
  assign byte_request_o = result_q.byte_request;
  assign read_data_o    = result_q.read_data;
  assign read_strobe_o  = result_q.read_strobe;
  assign finished_o     = result_q.finished;
  assign nack_error_o   = result_q.nack_error;
  assign busy_res_o     = result_q.busy_res;

  // A finished transaction leaves the master idle
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.finished) |-> !result_q.busy_res)
    else $error("finished while still busy");

  // An error flag only comes with the end of a transaction
  a_err_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.nack_error) |-> result_q.finished)
    else $error("nack error without finished");

  // A held word must step as soon as the result slot frees up
  a_step_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> (out_valid_q || !$past(in_valid_q)))
    else $error("held word did not advance");

endmodule

FILE: hw/rtl/i2c_rw_seq.sv
// ----------------------------------------------------------------------------
// I2C register access master - bus sequencer
// Holds the transaction state and advances it by one word per step.
// ----------------------------------------------------------------------------
module i2c_rw_seq #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2c_rw_pkg::item_t   item_i,
  output i2c_rw_pkg::result_t result_o
);

  logic [4:0]             phase_q, phase_d;
  logic [3:0]             bit_cnt_q, bit_cnt_d;
  logic [7:0]             shift_q, shift_d;
  logic [COUNT_WIDTH-1:0] bytes_left_q, bytes_left_d;
  logic [6:0]             saved_addr_q, saved_addr_d;
  logic [7:0]             saved_reg_q, saved_reg_d;
  logic                   read_mode_q, read_mode_d;
  logic                   byte_ready_q, byte_ready_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic [1:0]             stage_q, stage_d;
  logic                   nack_seen_q, nack_seen_d;

  logic [COUNT_WIDTH-1:0] bytes_dec;
  logic                   ack_level;
  logic [3:0]             bit_cnt_inc;
  logic [7:0]             shift_in;
  logic [7:0]             rdata;
  logic                   strobe, fin, err;

  assign bytes_dec   = (bytes_left_q != '0) ? bytes_left_q - COUNT_WIDTH'(1) : bytes_left_q;
  assign ack_level   = (bytes_left_q <= COUNT_WIDTH'(1));
  assign bit_cnt_inc = bit_cnt_q + 4'd1;
  assign shift_in    = {shift_q[6:0], item_i.sda_sample};

  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    bytes_left_d = bytes_left_q;
    saved_addr_d = saved_addr_q;
    saved_reg_d  = saved_reg_q;
    read_mode_d  = read_mode_q;
    byte_ready_d = byte_ready_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    stage_d      = stage_q;
    nack_seen_d  = nack_seen_q;
    rdata        = 8'd0;
    strobe       = 1'b0;
    fin          = 1'b0;
    err          = 1'b0;

    case (item_i.op)
      i2c_rw_pkg::OP_WRITE, i2c_rw_pkg::OP_READ: begin
        if (phase_q == i2c_rw_pkg::PH_IDLE) begin
          saved_addr_d = item_i.target_address;
          saved_reg_d  = item_i.register_index;
          bytes_left_d = item_i.byte_count[COUNT_WIDTH-1:0];
          read_mode_d  = (item_i.op == i2c_rw_pkg::OP_READ);
          stage_d      = i2c_rw_pkg::STG_ADDR_W;
          shift_d      = {item_i.target_address, 1'b0};
          bit_cnt_d    = 4'd0;
          byte_ready_d = 1'b0;
          nack_seen_d  = 1'b0;
          phase_d      = i2c_rw_pkg::PH_ST0;
        end
      end
      i2c_rw_pkg::OP_DATA: begin
        if (phase_q == i2c_rw_pkg::PH_WAIT && !byte_ready_q) begin
          shift_d      = item_i.write_data;
          byte_ready_d = 1'b1;
        end
      end
      default: begin
        case (phase_q)
          i2c_rw_pkg::PH_IDLE: ;
          i2c_rw_pkg::PH_ST0: begin
            scl_d = 1'b1; sda_d = 1'b1; phase_d = i2c_rw_pkg::PH_ST1;
          end
          i2c_rw_pkg::PH_ST1: begin
            scl_d = 1'b1; sda_d = 1'b0; phase_d = i2c_rw_pkg::PH_ST2;
          end
          i2c_rw_pkg::PH_ST2: begin
            scl_d = 1'b0; sda_d = 1'b0; bit_cnt_d = 4'd0;
            phase_d = i2c_rw_pkg::PH_WB0;
          end
          i2c_rw_pkg::PH_WAIT: begin
            if (byte_ready_q) begin
              byte_ready_d = 1'b0;
              bit_cnt_d    = 4'd0;
              scl_d        = 1'b0;
              sda_d        = shift_q[7];
              phase_d      = i2c_rw_pkg::PH_WB1;
            end
          end
          i2c_rw_pkg::PH_WB0: begin
            scl_d = 1'b0; sda_d = shift_q[7]; phase_d = i2c_rw_pkg::PH_WB1;
          end
          i2c_rw_pkg::PH_WB1: begin
            scl_d = 1'b1; sda_d = shift_q[7]; phase_d = i2c_rw_pkg::PH_WB2;
          end
          i2c_rw_pkg::PH_WB2: begin
            scl_d     = 1'b0;
            sda_d     = shift_q[7];
            shift_d   = {shift_q[6:0], 1'b0};
            bit_cnt_d = bit_cnt_inc;
            phase_d   = (bit_cnt_inc >= 4'(i2c_rw_pkg::BitsPerByte)) ?
                        i2c_rw_pkg::PH_WA0 : i2c_rw_pkg::PH_WB0;
          end
          i2c_rw_pkg::PH_WA0: begin
            scl_d = 1'b0; sda_d = 1'b1; phase_d = i2c_rw_pkg::PH_WA1;
          end
          i2c_rw_pkg::PH_WA1: begin
            scl_d = 1'b1; sda_d = 1'b1; phase_d = i2c_rw_pkg::PH_WA2;
          end
          i2c_rw_pkg::PH_WA2: begin
            scl_d = 1'b0;
            sda_d = 1'b1;
            if (item_i.sda_sample) begin
              // no ACK from the target: abort through STOP
              nack_seen_d = 1'b1;
              phase_d     = i2c_rw_pkg::PH_SP0;
            end else begin
              case (stage_q)
                i2c_rw_pkg::STG_ADDR_W: begin
                  stage_d   = i2c_rw_pkg::STG_REG;
                  shift_d   = saved_reg_q;
                  bit_cnt_d = 4'd0;
                  phase_d   = i2c_rw_pkg::PH_WB0;
                end
                i2c_rw_pkg::STG_REG: begin
                  if (read_mode_q) begin
                    stage_d = i2c_rw_pkg::STG_ADDR_R;
                    shift_d = {saved_addr_q, 1'b1};
                    phase_d = i2c_rw_pkg::PH_ST0;
                  end else begin
                    stage_d      = i2c_rw_pkg::STG_DATA;
                    byte_ready_d = 1'b0;
                    phase_d      = (bytes_left_q != '0) ?
                                   i2c_rw_pkg::PH_WAIT : i2c_rw_pkg::PH_SP0;
                  end
                end
                i2c_rw_pkg::STG_ADDR_R: begin
                  stage_d   = i2c_rw_pkg::STG_DATA;
                  bit_cnt_d = 4'd0;
                  shift_d   = 8'd0;
                  phase_d   = (bytes_left_q != '0) ?
                              i2c_rw_pkg::PH_RB0 : i2c_rw_pkg::PH_SP0;
                end
                default: begin
                  bytes_left_d = bytes_dec;
                  byte_ready_d = 1'b0;
                  phase_d      = (bytes_dec != '0) ?
                                 i2c_rw_pkg::PH_WAIT : i2c_rw_pkg::PH_SP0;
                end
              endcase
            end
          end
          i2c_rw_pkg::PH_RB0: begin
            scl_d = 1'b1; sda_d = 1'b1; phase_d = i2c_rw_pkg::PH_RB1;
          end
          i2c_rw_pkg::PH_RB1: begin
            scl_d     = 1'b0;
            sda_d     = 1'b1;
            shift_d   = shift_in;
            bit_cnt_d = bit_cnt_inc;
            if (bit_cnt_inc >= 4'(i2c_rw_pkg::BitsPerByte)) begin
              rdata   = shift_in;
              strobe  = 1'b1;
              phase_d = i2c_rw_pkg::PH_RA0;
            end else begin
              phase_d = i2c_rw_pkg::PH_RB0;
            end
          end
          i2c_rw_pkg::PH_RA0: begin
            scl_d = 1'b0; sda_d = ack_level; phase_d = i2c_rw_pkg::PH_RA1;
          end
          i2c_rw_pkg::PH_RA1: begin
            scl_d = 1'b1; sda_d = ack_level; phase_d = i2c_rw_pkg::PH_RA2;
          end
          i2c_rw_pkg::PH_RA2: begin
            scl_d        = 1'b0;
            sda_d        = ack_level;
            bytes_left_d = bytes_dec;
            bit_cnt_d    = 4'd0;
            shift_d      = 8'd0;
            phase_d      = (bytes_dec != '0) ? i2c_rw_pkg::PH_RB0 : i2c_rw_pkg::PH_SP0;
          end
          i2c_rw_pkg::PH_SP0: begin
            scl_d = 1'b1; sda_d = 1'b0; phase_d = i2c_rw_pkg::PH_SP1;
          end
          i2c_rw_pkg::PH_SP1: begin
            scl_d       = 1'b1;
            sda_d       = 1'b1;
            fin         = 1'b1;
            err         = nack_seen_q;
            nack_seen_d = 1'b0;
            phase_d     = i2c_rw_pkg::PH_IDLE;
          end
          default: phase_d = i2c_rw_pkg::PH_IDLE;
        endcase
      end
    endcase
  end

  always_comb begin
    result_o.scl_level    = scl_d;
    result_o.sda_level    = sda_d;
    result_o.byte_request = (phase_d == i2c_rw_pkg::PH_WAIT) && !byte_ready_d;
    result_o.read_data    = rdata;
    result_o.read_strobe  = strobe;
    result_o.finished     = fin;
    result_o.nack_error   = err;
    result_o.busy_res     = (phase_d != i2c_rw_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= i2c_rw_pkg::PH_IDLE;
      bit_cnt_q    <= 4'd0;
      shift_q      <= 8'd0;
      bytes_left_q <= '0;
      saved_addr_q <= 7'd0;
      saved_reg_q  <= 8'd0;
      read_mode_q  <= 1'b0;
      byte_ready_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      stage_q      <= i2c_rw_pkg::STG_ADDR_W;
      nack_seen_q  <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      bytes_left_q <= bytes_left_d;
      saved_addr_q <= saved_addr_d;
      saved_reg_q  <= saved_reg_d;
      read_mode_q  <= read_mode_d;
      byte_ready_q <= byte_ready_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      stage_q      <= stage_d;
      nack_seen_q  <= nack_seen_d;
    end
  end

  // Bit counter never runs past one byte
  a_bit_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= 4'(i2c_rw_pkg::BitsPerByte))
    else $error("bit counter past one byte");

  // A supplied byte is only held while waiting to send it
  a_byte_ready_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_ready_q |-> phase_q == i2c_rw_pkg::PH_WAIT)
    else $error("byte ready outside wait phase");

  // A pending abort always drains through STOP
  a_nack_in_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nack_seen_q |-> (phase_q == i2c_rw_pkg::PH_SP0 || phase_q == i2c_rw_pkg::PH_SP1))
    else $error("nack pending outside STOP");

endmodule
